// ===== src/ucs_pkg.sv =====
// Package for the URL component splitter: shared widths, character codes,
// phase and status encodings and the result record.
// No dependencies; every other file of the block imports it.
`default_nettype none

package ucs_pkg;

  // Longest URL that is parsed; later bytes are only counted.
  localparam int MAX_URL_LENGTH = 4096;
  localparam int MIN_URL_LENGTH = 8;

  // Byte counter must hold MAX_URL_LENGTH + 1 to flag an overlong URL.
  localparam int POS_W = $clog2(MAX_URL_LENGTH + 2);

  // Fixed widths of the result fields.
  localparam int OFF_W  = 12;
  localparam int LEN_W  = 13;
  localparam int PORT_W = 16;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_URL_LENGTH);
  localparam logic [POS_W-1:0] MIN_POS = POS_W'(MIN_URL_LENGTH);

  // Character codes.
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  // Scheme prefixes in lower case; the http one is padded with a NUL.
  localparam logic [7:0] PAT_HTTP [8] = '{8'h68, 8'h74, 8'h74, 8'h70,
                                          8'h3A, 8'h2F, 8'h2F, 8'h00};
  localparam logic [7:0] PAT_HTTPS [8] = '{8'h68, 8'h74, 8'h74, 8'h70,
                                           8'h73, 8'h3A, 8'h2F, 8'h2F};

  localparam logic [2:0] HTTP_LAST_IDX  = 3'd6;
  localparam logic [2:0] HTTPS_LAST_IDX = 3'd7;

  // Scheme defaults.
  localparam logic [PORT_W-1:0] PORT_HTTP  = 16'd80;
  localparam logic [PORT_W-1:0] PORT_HTTPS = 16'd443;
  localparam logic [POS_W-1:0]  HOST_OFF_HTTP  = POS_W'(7);
  localparam logic [POS_W-1:0]  HOST_OFF_HTTPS = POS_W'(8);

  // Scheme kind as reported.
  localparam logic [1:0] SCHEME_NONE  = 2'd0;
  localparam logic [1:0] SCHEME_HTTP  = 2'd1;
  localparam logic [1:0] SCHEME_HTTPS = 2'd2;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_SCHEME = 3'd2,
    ST_HOST   = 3'd3,
    ST_PORT   = 3'd4,
    ST_LONG   = 3'd5
  } status_e;

  typedef enum logic [6:0] {
    PH_SCHEME = 7'b0000001,
    PH_HOST   = 7'b0000010,
    PH_PORT   = 7'b0000100,
    PH_PATH   = 7'b0001000,
    PH_QUERY  = 7'b0010000,
    PH_ANCHOR = 7'b0100000,
    PH_SKIP   = 7'b1000000
  } phase_e;

  // One result record.
  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        scheme_kind;
    logic [PORT_W-1:0] port_number;
    logic [OFF_W-1:0]  host_offset;
    logic [LEN_W-1:0]  host_length;
    logic [OFF_W-1:0]  path_offset;
    logic [LEN_W-1:0]  path_length;
    logic [OFF_W-1:0]  query_offset;
    logic [LEN_W-1:0]  query_length;
    logic [OFF_W-1:0]  anchor_offset;
    logic [LEN_W-1:0]  anchor_length;
  } res_t;

  // Fold an ASCII capital to lower case.
  function automatic logic [7:0] to_lower(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b | 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/ucs_if.sv =====
// Valid/ready channel interfaces of the URL component splitter: the byte
// input channel and the result output channel.
// Depends on ucs_pkg for field widths.
`default_nettype none

interface ucs_in_if import ucs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       is_last;

  modport source (output valid, output url_byte, output is_last, input ready);
  modport sink   (input valid, input url_byte, input is_last, output ready);
endinterface

interface ucs_out_if import ucs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [1:0]        scheme_kind;
  logic [PORT_W-1:0] port_number;
  logic [OFF_W-1:0]  host_offset;
  logic [LEN_W-1:0]  host_length;
  logic [OFF_W-1:0]  path_offset;
  logic [LEN_W-1:0]  path_length;
  logic [OFF_W-1:0]  query_offset;
  logic [LEN_W-1:0]  query_length;
  logic [OFF_W-1:0]  anchor_offset;
  logic [LEN_W-1:0]  anchor_length;

  modport source (output valid, output status, output scheme_kind, output port_number,
                  output host_offset, output host_length, output path_offset,
                  output path_length, output query_offset, output query_length,
                  output anchor_offset, output anchor_length, input ready);
  modport sink   (input valid, input status, input scheme_kind, input port_number,
                  input host_offset, input host_length, input path_offset,
                  input path_length, input query_offset, input query_length,
                  input anchor_offset, input anchor_length, output ready);
endinterface

`default_nettype wire

// ===== src/url_component_splitter.sv =====
// URL component splitter: takes an http or https URL one byte per beat and,
// on the beat flagged last, delivers one result with the status, scheme,
// port and the offset and length of host, path, query and anchor. Bytes
// flow in without gaps unless the input stalls; the last byte's result is
// registered in the result register, or in the skid register if the
// result register is full and not being taken. This two-entry output buffer
// lets bytes keep flowing while one result waits; the input stalls only
// when both entries hold results that have not been taken.
// Depends on ucs_pkg, ucs_if and ucs_parser.
`default_nettype none

module url_component_splitter import ucs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ucs_in_if.sink     byte_i,
  ucs_out_if.source  result_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t res_q, skid_q, new_res;
  logic in_beat, out_beat, new_result;
  logic load_out, load_skid, from_skid;

  assign byte_i.ready = !skid_valid_q;
  assign in_beat      = byte_i.valid && byte_i.ready;
  assign out_beat     = out_valid_q && result_o.ready;
  assign new_result   = in_beat && byte_i.is_last;

  ucs_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .beat_i     (in_beat),
    .url_byte_i (byte_i.url_byte),
    .is_last_i  (byte_i.is_last),
    .res_o      (new_res)
  );

  // Output buffer control.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    from_skid    = 1'b0;
    if (skid_valid_q) begin
      if (out_beat) begin
        load_out     = 1'b1;
        from_skid    = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (new_result) begin
      if (!out_valid_q || out_beat) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (out_beat) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q <= from_skid ? skid_q : new_res;
    end
    if (load_skid) begin
      skid_q <= new_res;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.status        = res_q.status;
  assign result_o.scheme_kind   = res_q.scheme_kind;
  assign result_o.port_number   = res_q.port_number;
  assign result_o.host_offset   = res_q.host_offset;
  assign result_o.host_length   = res_q.host_length;
  assign result_o.path_offset   = res_q.path_offset;
  assign result_o.path_length   = res_q.path_length;
  assign result_o.query_offset  = res_q.query_offset;
  assign result_o.query_length  = res_q.query_length;
  assign result_o.anchor_offset = res_q.anchor_offset;
  assign result_o.anchor_length = res_q.anchor_length;

  // The skid entry is only ever filled behind a full result register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while result register is empty");

  // A last byte that meets a stalled, full result register lands in the skid.
  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (new_result && out_valid_q && !result_o.ready) |=> skid_valid_q)
    else $error("result lost while output was stalled");

  // An error result carries nothing but its status.
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_o.status != ST_OK) |->
      (result_o.scheme_kind == SCHEME_NONE && result_o.port_number == '0 &&
       result_o.host_length == '0 && result_o.query_offset == '0))
    else $error("error result with nonzero fields");

  // A good result names a scheme whose prefix length is the host offset.
  a_ok_scheme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_o.status == ST_OK) |->
      ((result_o.scheme_kind == SCHEME_HTTP &&
        result_o.host_offset == HOST_OFF_HTTP[OFF_W-1:0]) ||
       (result_o.scheme_kind == SCHEME_HTTPS &&
        result_o.host_offset == HOST_OFF_HTTPS[OFF_W-1:0])))
    else $error("good result with inconsistent scheme and host offset");

endmodule

`default_nettype wire

// ===== src/ucs_parser.sv =====
// Byte-at-a-time URL parse state: phase, byte count, scheme match, port
// accumulator and field marks, plus the result record of the last beat.
// Depends on ucs_pkg.
`default_nettype none

module ucs_parser import ucs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       beat_i,
  input  wire logic [7:0] url_byte_i,
  input  wire logic       is_last_i,
  output res_t            res_o
);

  phase_e             phase_q, phase_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [2:0]         idx_q, idx_d;
  logic [1:0]         seen_q, seen_d;
  logic [PORT_W-1:0]  port_q, port_d;
  status_e            err_q, err_d;
  logic [POS_W-1:0]   host_off_q, host_off_d, host_len_q, host_len_d;
  logic [POS_W-1:0]   path_off_q, path_off_d, path_len_q, path_len_d;
  logic [POS_W-1:0]   query_off_q, query_off_d, query_len_q, query_len_d;
  logic [POS_W-1:0]   anchor_off_q, anchor_off_d, anchor_len_q, anchor_len_d;

  logic [7:0]         lc;
  logic [1:0]         seen_m;
  logic [7:0]         dsub;
  logic [POS_W-1:0]   pos_p1;
  logic [POS_W-1:0]   host_gap;
  logic               parse_en;

  // Finishing values of the last beat.
  logic [POS_W-1:0]   len;
  logic [POS_W-1:0]   host_len_f, path_len_f, query_len_f, anchor_len_f;
  status_e            err_f, status_f;

  assign lc       = to_lower(url_byte_i);
  assign dsub     = url_byte_i - CH_ZERO;
  assign pos_p1   = pos_q + POS_W'(1);
  assign host_gap = pos_q - host_off_q;
  assign parse_en = pos_q < MAX_POS;

  // Next state for one byte.
  always_comb begin
    phase_d      = phase_q;
    idx_d        = idx_q;
    seen_d       = seen_q;
    port_d       = port_q;
    err_d        = err_q;
    host_off_d   = host_off_q;
    host_len_d   = host_len_q;
    path_off_d   = path_off_q;
    path_len_d   = path_len_q;
    query_off_d  = query_off_q;
    query_len_d  = query_len_q;
    anchor_off_d = anchor_off_q;
    anchor_len_d = anchor_len_q;
    seen_m       = seen_q;
    pos_d        = (pos_q <= MAX_POS) ? pos_p1 : pos_q;

    if (parse_en) begin
      unique case (phase_q)
        PH_SCHEME: begin
          // Track mismatches against both prefixes in parallel.
          seen_m[0] = seen_q[0] | (idx_q == HTTPS_LAST_IDX) | (lc != PAT_HTTP[idx_q]);
          seen_m[1] = seen_q[1] | (lc != PAT_HTTPS[idx_q]);
          seen_d    = seen_m;
          idx_d     = idx_q + 3'd1;
          if (idx_q == HTTP_LAST_IDX && !seen_m[0]) begin
            seen_d     = SCHEME_HTTP;
            port_d     = PORT_HTTP;
            host_off_d = HOST_OFF_HTTP;
            phase_d    = PH_HOST;
          end else if (idx_q == HTTPS_LAST_IDX) begin
            if (!seen_m[1]) begin
              seen_d     = SCHEME_HTTPS;
              port_d     = PORT_HTTPS;
              host_off_d = HOST_OFF_HTTPS;
              phase_d    = PH_HOST;
            end else begin
              err_d   = ST_SCHEME;
              phase_d = PH_SKIP;
            end
          end
        end
        PH_HOST: begin
          // Host ends only at a colon or a slash, or at the end of the URL.
          if (url_byte_i == CH_COLON || url_byte_i == CH_SLASH) begin
            host_len_d = host_gap;
            if (host_gap == '0) begin
              err_d   = ST_HOST;
              phase_d = PH_SKIP;
            end else if (url_byte_i == CH_COLON) begin
              port_d  = '0;
              phase_d = PH_PORT;
            end else begin
              path_off_d = pos_q;
              phase_d    = PH_PATH;
            end
          end
        end
        PH_PORT: begin
          // Decimal accumulate: port * 10 + digit, wrapping at 16 bits.
          if (url_byte_i >= CH_ZERO && url_byte_i <= CH_NINE) begin
            port_d = (port_q << 3) + (port_q << 1) + {12'b0, dsub[3:0]};
          end else if (url_byte_i == CH_SLASH) begin
            path_off_d = pos_q;
            phase_d    = PH_PATH;
          end else begin
            err_d   = ST_PORT;
            phase_d = PH_SKIP;
          end
        end
        PH_PATH: begin
          if (url_byte_i == CH_QMARK || url_byte_i == CH_HASH) begin
            path_len_d = pos_q - path_off_q;
            if (url_byte_i == CH_QMARK) begin
              query_off_d = pos_p1;
              phase_d     = PH_QUERY;
            end else begin
              anchor_off_d = pos_p1;
              phase_d      = PH_ANCHOR;
            end
          end
        end
        PH_QUERY: begin
          if (url_byte_i == CH_HASH) begin
            query_len_d  = pos_q - query_off_q;
            anchor_off_d = pos_p1;
            phase_d      = PH_ANCHOR;
          end
        end
        PH_ANCHOR, PH_SKIP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Close the open field at the end of the URL and pick the status.
  always_comb begin
    len          = pos_d;
    host_len_f   = host_len_d;
    path_len_f   = path_len_d;
    query_len_f  = query_len_d;
    anchor_len_f = anchor_len_d;
    err_f        = err_d;
    if (phase_d == PH_HOST) begin
      host_len_f = len - host_off_d;
      if (host_len_f == '0) begin
        err_f = ST_HOST;
      end
    end
    if (phase_d == PH_PATH) begin
      path_len_f = len - path_off_d;
    end
    if (phase_d == PH_QUERY) begin
      query_len_f = len - query_off_d;
    end
    if (phase_d == PH_ANCHOR) begin
      anchor_len_f = len - anchor_off_d;
    end

    if (len > MAX_POS) begin
      status_f = ST_LONG;
    end else if (len < MIN_POS) begin
      status_f = ST_SHORT;
    end else begin
      status_f = err_f;
    end
  end

  // Result record; every field but the status is zero on an error.
  always_comb begin
    res_o        = '0;
    res_o.status = status_f;
    if (status_f == ST_OK) begin
      res_o.scheme_kind   = seen_d;
      res_o.port_number   = port_d;
      res_o.host_offset   = host_off_d[OFF_W-1:0];
      res_o.host_length   = LEN_W'(host_len_f);
      if (path_len_f != '0) begin
        res_o.path_offset = path_off_d[OFF_W-1:0];
        res_o.path_length = LEN_W'(path_len_f);
      end
      res_o.query_offset  = query_off_d[OFF_W-1:0];
      res_o.query_length  = LEN_W'(query_len_f);
      res_o.anchor_offset = anchor_off_d[OFF_W-1:0];
      res_o.anchor_length = LEN_W'(anchor_len_f);
    end
  end

  // State update; the last beat of a URL returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SCHEME;
      pos_q        <= '0;
      idx_q        <= '0;
      seen_q       <= '0;
      port_q       <= '0;
      err_q        <= ST_OK;
      host_off_q   <= '0;
      host_len_q   <= '0;
      path_off_q   <= '0;
      path_len_q   <= '0;
      query_off_q  <= '0;
      query_len_q  <= '0;
      anchor_off_q <= '0;
      anchor_len_q <= '0;
    end else if (beat_i) begin
      if (is_last_i) begin
        phase_q      <= PH_SCHEME;
        pos_q        <= '0;
        idx_q        <= '0;
        seen_q       <= '0;
        port_q       <= '0;
        err_q        <= ST_OK;
        host_off_q   <= '0;
        host_len_q   <= '0;
        path_off_q   <= '0;
        path_len_q   <= '0;
        query_off_q  <= '0;
        query_len_q  <= '0;
        anchor_off_q <= '0;
        anchor_len_q <= '0;
      end else begin
        phase_q      <= phase_d;
        pos_q        <= pos_d;
        idx_q        <= idx_d;
        seen_q       <= seen_d;
        port_q       <= port_d;
        err_q        <= err_d;
        host_off_q   <= host_off_d;
        host_len_q   <= host_len_d;
        path_off_q   <= path_off_d;
        path_len_q   <= path_len_d;
        query_off_q  <= query_off_d;
        query_len_q  <= query_len_d;
        anchor_off_q <= anchor_off_d;
        anchor_len_q <= anchor_len_d;
      end
    end
  end

endmodule

`default_nettype wire
